### src/hcc_pkg.sv
// Shared types and constants of the heat-map cell colouriser.
// No dependencies; imported by every module of the block.
package hcc_pkg;

    localparam int HCC_VALUE_BITS      = 32;
    localparam int HCC_RATIO_FRAC_BITS = 16;
    localparam int CFG_DATA_BITS       = 32;
    localparam int CFG_ADDR_BITS       = 2;
    localparam int NUM_SEGS            = 5;
    localparam int NUM_STOPS           = NUM_SEGS + 1;
    localparam int RECIP_SHIFT         = 14;

    localparam logic [CFG_ADDR_BITS-1:0] REG_RANGE_MIN = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RANGE_MAX = 2'd1;

    // stop positions in twentieths of the full range, per segment
    localparam logic [4:0] SEG_LEFT  [0:NUM_SEGS-1] = '{5'd0, 5'd5, 5'd10, 5'd15, 5'd18};
    localparam logic [4:0] SEG_RIGHT [0:NUM_SEGS-1] = '{5'd5, 5'd10, 5'd15, 5'd18, 5'd20};
    localparam logic [2:0] SEG_SPAN  [0:NUM_SEGS-1] = '{3'd5, 3'd5, 3'd5, 3'd3, 3'd2};
    // ceil(2^RECIP_SHIFT / span): exact quotient for numerators up to 255 * span
    localparam logic [13:0] SEG_RECIP [0:NUM_SEGS-1] =
        '{14'd3277, 14'd3277, 14'd3277, 14'd5462, 14'd8192};

    localparam logic [7:0] STOP_RGB [0:NUM_STOPS-1][0:2] = '{
        '{8'h8a, 8'ha8, 8'hff},
        '{8'h9d, 8'hd9, 8'hff},
        '{8'h9a, 8'hf0, 8'ha0},
        '{8'he4, 8'hee, 8'h8e},
        '{8'hf3, 8'hb0, 8'h7b},
        '{8'he5, 8'h8e, 8'h8e}
    };

    localparam logic [17:0] LUM_COEF_R = 18'd299;
    localparam logic [17:0] LUM_COEF_G = 18'd587;
    localparam logic [17:0] LUM_COEF_B = 18'd114;
    localparam logic [17:0] LUM_LIMIT  = 18'd120000;

    typedef enum logic [1:0] {
        RM_DIV,
        RM_HALF,
        RM_ZERO,
        RM_ONE
    } t_ratio_mode;

    typedef struct packed {
        logic vld;
        logic numeric;
    } t_tag;

endpackage

### src/heatmap_cell_colorizer_core.sv
// Top level of the heat-map cell colouriser: range registers and the two pipeline halves.
// Depends on hcc_pkg, hcc_ratio and hcc_grad.
//
//  channel   direction  handshake             payload
//  config    in         i_cfg_we              i_cfg_addr, i_cfg_wdata
//  cell      in         i_start && !o_busy    i_cell_value, i_is_numeric
//  colour    out        o_valid (strobe)      o_red, o_green, o_blue, o_text_white
//
// One cell per clock; each result passes the registered range compare, the divider, which
// retires one quotient bit per stage, and the gradient stages before it leaves.
// o_busy stays low: the pipeline never stalls and the receiver cannot hold results off.
// Synchronous active-low reset clears the range registers and the valid bits in flight.
module heatmap_cell_colorizer_core import hcc_pkg::*; #(
    parameter int VALUE_BITS      = HCC_VALUE_BITS,
    parameter int RATIO_FRAC_BITS = HCC_RATIO_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [VALUE_BITS-1:0]    i_cell_value,
    input  logic                     i_is_numeric,
    output logic                     o_valid,
    output logic [7:0]               o_red,
    output logic [7:0]               o_green,
    output logic [7:0]               o_blue,
    output logic                     o_text_white
);

    logic [CFG_DATA_BITS-1:0] r_range_min, r_range_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min <= '0;
            r_range_max <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_RANGE_MIN: r_range_min <= i_cfg_wdata;
                REG_RANGE_MAX: r_range_max <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    t_tag                     in_tag, ratio_tag;
    logic [RATIO_FRAC_BITS:0] ratio;

    always_comb begin
        in_tag.vld     = i_start && !o_busy;
        in_tag.numeric = i_is_numeric;
    end

    hcc_ratio #(
        .VALUE_BITS      (VALUE_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_ratio (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (in_tag),
        .i_cell_value (i_cell_value),
        .i_range_min  (r_range_min),
        .i_range_max  (r_range_max),
        .o_tag        (ratio_tag),
        .o_ratio      (ratio)
    );

    hcc_grad #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_grad (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (ratio_tag),
        .i_ratio      (ratio),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_text_white (o_text_white)
    );

endmodule

### src/hcc_ratio.sv
// Range compare and pipelined restoring divider giving the normalised ratio.
// Depends on hcc_pkg.
module hcc_ratio import hcc_pkg::*; #(
    parameter int VALUE_BITS      = HCC_VALUE_BITS,
    parameter int RATIO_FRAC_BITS = HCC_RATIO_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_tag                       i_tag,
    input  logic [VALUE_BITS-1:0]      i_cell_value,
    input  logic [CFG_DATA_BITS-1:0]   i_range_min,
    input  logic [CFG_DATA_BITS-1:0]   i_range_max,
    output t_tag                       o_tag,
    output logic [RATIO_FRAC_BITS:0]   o_ratio
);

    localparam int VB       = VALUE_BITS;
    localparam int F        = RATIO_FRAC_BITS;
    localparam int STEPS    = F + 1;
    localparam int EXT_BITS = (VB > CFG_DATA_BITS) ? VB : CFG_DATA_BITS;

    logic [EXT_BITS-1:0] lo_ext, hi_ext;
    logic signed [VB:0]  lo_s, hi_s, v_s, num_s, den_s;
    t_ratio_mode         front_mode;

    always_comb begin
        lo_ext = EXT_BITS'(i_range_min);
        hi_ext = EXT_BITS'(i_range_max);
        lo_s   = $signed({lo_ext[VB-1], lo_ext[VB-1:0]});
        hi_s   = $signed({hi_ext[VB-1], hi_ext[VB-1:0]});
        v_s    = $signed({i_cell_value[VB-1], i_cell_value});
        num_s  = v_s - lo_s;
        den_s  = hi_s - lo_s;
        if (hi_s <= lo_s) begin
            front_mode = RM_HALF;
        end else if (v_s <= lo_s) begin
            front_mode = RM_ZERO;
        end else if (v_s >= hi_s) begin
            front_mode = RM_ONE;
        end else begin
            front_mode = RM_DIV;
        end
    end

    t_tag          r_tag  [0:STEPS];
    t_ratio_mode   r_mode [0:STEPS];
    logic [VB-1:0] r_den  [0:STEPS];
    logic [VB-1:0] r_rem  [0:STEPS];
    logic [F:0]    r_q    [0:STEPS];

    logic [VB:0]   n_sh   [1:STEPS];
    logic          n_ge   [1:STEPS];
    logic [VB-1:0] n_rem  [1:STEPS];
    logic [F:0]    n_q    [1:STEPS];

    // one quotient bit per stage
    always_comb begin
        for (int s = 1; s <= STEPS; s++) begin
            n_sh[s]  = {r_rem[s-1], 1'b0};
            n_ge[s]  = n_sh[s] >= {1'b0, r_den[s-1]};
            n_rem[s] = n_ge[s] ? VB'(n_sh[s] - {1'b0, r_den[s-1]}) : n_sh[s][VB-1:0];
            n_q[s]   = {r_q[s-1][F-1:0], n_ge[s]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= STEPS; s++) begin
                r_tag[s] <= '0;
            end
        end else begin
            r_tag[0] <= i_tag;
            for (int s = 1; s <= STEPS; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode[0] <= front_mode;
        r_den[0]  <= den_s[VB-1:0];
        r_rem[0]  <= num_s[VB-1:0];
        r_q[0]    <= '0;
        for (int s = 1; s <= STEPS; s++) begin
            r_mode[s] <= r_mode[s-1];
            r_den[s]  <= r_den[s-1];
            r_rem[s]  <= n_rem[s];
            r_q[s]    <= n_q[s];
        end
    end

    // round to nearest, ties up, from one extra quotient bit
    logic [F+1:0] q_rnd;
    logic [F:0]   n_ratio;

    always_comb begin
        q_rnd = {1'b0, r_q[STEPS]} + (F+2)'(1);
        case (r_mode[STEPS])
            RM_HALF: n_ratio = (F+1)'(1) << (F - 1);
            RM_ZERO: n_ratio = '0;
            RM_ONE:  n_ratio = (F+1)'(1) << F;
            RM_DIV:  n_ratio = q_rnd[F+1:1];
            default: n_ratio = '0;
        endcase
    end

    t_tag       r_out_tag;
    logic [F:0] r_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_tag <= '0;
        end else begin
            r_out_tag <= r_tag[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ratio <= n_ratio;
    end

    assign o_tag   = r_out_tag;
    assign o_ratio = r_ratio;

endmodule

### src/hcc_grad.sv
// Six-stop gradient interpolation with half-even rounding and text contrast pick.
// Depends on hcc_pkg.
module hcc_grad import hcc_pkg::*; #(
    parameter int RATIO_FRAC_BITS = HCC_RATIO_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tag                     i_tag,
    input  logic [RATIO_FRAC_BITS:0] i_ratio,
    output logic                     o_valid,
    output logic [7:0]               o_red,
    output logic [7:0]               o_green,
    output logic [7:0]               o_blue,
    output logic                     o_text_white
);

    localparam int F = RATIO_FRAC_BITS;

    t_tag r_tag1, r_tag2, r_tag3, r_tag4, r_tag5, r_tag6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_tag4 <= '0;
            r_tag5 <= '0;
            r_tag6 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
            r_tag4 <= r_tag3;
            r_tag5 <= r_tag4;
            r_tag6 <= r_tag5;
        end
    end

    // stage 1: segment search and offset into the segment
    logic [F+4:0] r20;
    logic [F+4:0] left_pos;
    logic [2:0]   n_seg1;

    always_comb begin
        r20    = (F+5)'({i_ratio, 4'b0}) + (F+5)'({i_ratio, 2'b0});
        n_seg1 = 3'(NUM_SEGS - 1);
        for (int s = NUM_SEGS - 2; s >= 0; s--) begin
            if (r20 <= {SEG_RIGHT[s], {F{1'b0}}}) begin
                n_seg1 = 3'(s);
            end
        end
        left_pos = {SEG_LEFT[n_seg1], {F{1'b0}}};
    end

    logic [2:0]   r_seg1;
    logic [F+2:0] r_off1;

    always_ff @(posedge i_clk) begin
        r_seg1 <= n_seg1;
        r_off1 <= (F+3)'(r20 - left_pos);
    end

    // stage 2: colour step times offset, left colour times span
    logic signed [8:0]    delta [0:2];
    logic signed [F+3:0]  off_s;
    logic signed [F+12:0] n_prod [0:2];
    logic [10:0]          n_lk   [0:2];

    always_comb begin
        off_s = $signed({1'b0, r_off1});
        for (int c = 0; c < 3; c++) begin
            delta[c]  = $signed({1'b0, STOP_RGB[r_seg1 + 3'd1][c]})
                      - $signed({1'b0, STOP_RGB[r_seg1][c]});
            n_prod[c] = delta[c] * off_s;
            n_lk[c]   = 11'(STOP_RGB[r_seg1][c]) * 11'(SEG_SPAN[r_seg1]);
        end
    end

    logic [2:0]           r_seg2;
    logic signed [F+12:0] r_prod2 [0:2];
    logic [10:0]          r_lk2   [0:2];

    always_ff @(posedge i_clk) begin
        r_seg2 <= r_seg1;
        for (int c = 0; c < 3; c++) begin
            r_prod2[c] <= n_prod[c];
            r_lk2[c]   <= n_lk[c];
        end
    end

    // stage 3: numerator over 2^F split into integer part and low bits
    logic signed [12:0] tsum [0:2];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            tsum[c] = $signed({2'b0, r_lk2[c]}) + $signed(r_prod2[c][F+12:F]);
        end
    end

    logic [2:0]   r_seg3;
    logic [10:0]  r_thi3 [0:2];
    logic [F-1:0] r_low3 [0:2];

    always_ff @(posedge i_clk) begin
        r_seg3 <= r_seg2;
        for (int c = 0; c < 3; c++) begin
            r_thi3[c] <= tsum[c][10:0];
            r_low3[c] <= r_prod2[c][F-1:0];
        end
    end

    // stage 4: divide the integer part by the span via reciprocal
    logic [24:0] recip_prod [0:2];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            recip_prod[c] = 25'(r_thi3[c]) * 25'(SEG_RECIP[r_seg3]);
        end
    end

    logic [2:0]   r_seg4;
    logic [10:0]  r_thi4 [0:2];
    logic [F-1:0] r_low4 [0:2];
    logic [7:0]   r_q4   [0:2];

    always_ff @(posedge i_clk) begin
        r_seg4 <= r_seg3;
        for (int c = 0; c < 3; c++) begin
            r_thi4[c] <= r_thi3[c];
            r_low4[c] <= r_low3[c];
            r_q4[c]   <= recip_prod[c][RECIP_SHIFT+7:RECIP_SHIFT];
        end
    end

    // stage 5: remainder against half the segment width, ties to even
    logic [10:0]  rem_hi [0:2];
    logic [F+3:0] rem2   [0:2];
    logic [F+3:0] seg_w;
    logic         rnd_up [0:2];
    logic [7:0]   n_chan [0:2];

    always_comb begin
        seg_w = (F+4)'({SEG_SPAN[r_seg4], {F{1'b0}}});
        for (int c = 0; c < 3; c++) begin
            rem_hi[c] = r_thi4[c] - 11'(r_q4[c]) * 11'(SEG_SPAN[r_seg4]);
            rem2[c]   = {rem_hi[c][2:0], r_low4[c], 1'b0};
            rnd_up[c] = (rem2[c] > seg_w) || ((rem2[c] == seg_w) && r_q4[c][0]);
            n_chan[c] = r_q4[c] + 8'(rnd_up[c]);
        end
    end

    logic [7:0] r_chan5 [0:2];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_chan5[c] <= n_chan[c];
        end
    end

    // stage 6: luminance and text-cell override
    logic [17:0] lum;

    always_comb begin
        lum = 18'(r_chan5[0]) * LUM_COEF_R
            + 18'(r_chan5[1]) * LUM_COEF_G
            + 18'(r_chan5[2]) * LUM_COEF_B;
    end

    logic [7:0] r_red, r_green, r_blue;
    logic       r_text_white;

    always_ff @(posedge i_clk) begin
        if (r_tag5.numeric) begin
            r_red        <= r_chan5[0];
            r_green      <= r_chan5[1];
            r_blue       <= r_chan5[2];
            r_text_white <= lum < LUM_LIMIT;
        end else begin
            r_red        <= 8'hff;
            r_green      <= 8'hff;
            r_blue       <= 8'hff;
            r_text_white <= 1'b0;
        end
    end

    assign o_valid      = r_tag6.vld;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_text_white = r_text_white;

endmodule
